FILE: rtl/core/binary_table_search_defines.svh
// ----------------------------------------------------------------------------
// Binary table search: assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_TABLE_SEARCH_DEFINES_SVH
`define BINARY_TABLE_SEARCH_DEFINES_SVH

// Consequence holds in the same cycle as the trigger.
`define BTS_ASSERT_NOW(label, trig, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (conseq)) \
    else $error(msg);

// Consequence holds in the cycle after the trigger.
`define BTS_ASSERT_NEXT(label, trig, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (conseq)) \
    else $error(msg);

`endif

FILE: rtl/core/bts_pkg.sv
// ----------------------------------------------------------------------------
// Binary table search package
// Table geometry, field widths, request op codes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bts_pkg;

  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BOUND_W = $clog2(DEPTH + 1);

  localparam int OP_W    = 1;
  localparam int INDEX_W = 10;
  localparam int DATA_W  = 16;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 10;

  localparam logic [OP_W-1:0] OP_LOAD   = 1'b0;
  localparam logic [OP_W-1:0] OP_SEARCH = 1'b1;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } res_t;

endpackage

FILE: rtl/core/bts_engine.sv
// ----------------------------------------------------------------------------
// Binary table search engine
// Table memory with one registered read port and the interval-halving
// sequencer that probes it one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bts_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [bts_pkg::OP_W-1:0]            op,
  input  logic [bts_pkg::INDEX_W-1:0]         index,
  input  logic signed [bts_pkg::DATA_W-1:0]   entry,
  input  logic signed [bts_pkg::DATA_W-1:0]   key,
  input  logic [bts_pkg::COUNT_W-1:0]         count,
  output logic                                idle,
  output logic                                res_valid,
  output bts_pkg::res_t                       res,
  input  logic                                res_take
);

  localparam int AW = bts_pkg::ADDR_W;
  localparam int BW = bts_pkg::BOUND_W;

  typedef enum logic [1:0] {S_IDLE, S_PROBE, S_DONE} state_t;

  state_t                          state;
  logic signed [bts_pkg::DATA_W-1:0] mem [bts_pkg::DEPTH];
  logic signed [bts_pkg::DATA_W-1:0] rdata;
  logic signed [bts_pkg::DATA_W-1:0] key_r;
  logic [BW-1:0]                   lo;
  logic [BW-1:0]                   hi1;   // exclusive upper bound
  logic [AW-1:0]                   mid;

  logic [BW-1:0] n;
  logic [AW-1:0] mid0;
  logic          hit;
  logic          lt;
  logic [BW-1:0] lo_next;
  logic [BW-1:0] hi1_next;
  logic [BW:0]   sum_next;
  logic [AW-1:0] mid_next;
  logic          more;
  logic          load_ok;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  always_comb begin
    n        = (32'(count) > bts_pkg::DEPTH) ? BW'(bts_pkg::DEPTH) : BW'(count);
    mid0     = AW'(((BW + 1)'(n) - (BW + 1)'(1)) >> 1);
    hit      = (rdata == key_r);
    lt       = (key_r < rdata);
    lo_next  = lt ? lo : (BW'(mid) + BW'(1));
    hi1_next = lt ? BW'(mid) : hi1;
    sum_next = (BW + 1)'(lo_next) + (BW + 1)'(hi1_next) - (BW + 1)'(1);
    mid_next = AW'(sum_next >> 1);
    more     = (lo_next < hi1_next);
    load_ok  = (32'(index) < bts_pkg::DEPTH);
    rd_addr  = (state == S_IDLE) ? mid0 : mid_next;
    rd_en    = ((state == S_IDLE) && take && (op == bts_pkg::OP_SEARCH) && (n != '0)) ||
               ((state == S_PROBE) && !hit && more);
  end

  // Loads are only taken while idle, so writes never meet a probe in flight.
  always_ff @(posedge clk) begin
    if (take && (state == S_IDLE) && (op == bts_pkg::OP_LOAD) && load_ok) begin
      mem[AW'(index)] <= entry;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take && (op == bts_pkg::OP_SEARCH)) begin
            key_r <= key;
            lo    <= '0;
            hi1   <= n;
            mid   <= mid0;
            if (n == '0) begin
              res   <= '0;
              state <= S_DONE;
            end else begin
              state <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (hit) begin
            res.found    <= 1'b1;
            res.position <= bts_pkg::POS_W'(mid);
            state        <= S_DONE;
          end else if (more) begin
            lo  <= lo_next;
            hi1 <= hi1_next;
            mid <= mid_next;
          end else begin
            res   <= '0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register takes it
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

endmodule

FILE: rtl/core/binary_table_search.sv
// ----------------------------------------------------------------------------
// Binary table search
// Loads a table of signed entries and answers key searches by interval
// halving over the entries in use.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+---------------------------
//  request   | req_valid / req_stall     | op, index, entry, key
//  response  | rsp_valid / rsp_stall     | found, position
//  config    | cfg_we                    | cfg_wdata (table_count)
//
//  A load writes its entry and leaves the sequencer idle. A search makes
//  up to log2(DEPTH) + 1 probes, one memory read per probe through the
//  single registered read port.
//  Reset (rst, synchronous) returns the sequencer to idle and clears
//  table_count; the table holds whatever was last loaded.
//  A finished result waits in the response register; the next request is
//  accepted meanwhile, and a further result holds in the engine while
//  rsp_stall is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_table_search (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bts_pkg::COUNT_W-1:0]         cfg_wdata,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic [bts_pkg::OP_W-1:0]            op,
  input  logic [bts_pkg::INDEX_W-1:0]         index,
  input  logic signed [bts_pkg::DATA_W-1:0]   entry,
  input  logic signed [bts_pkg::DATA_W-1:0]   key,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                found,
  output logic [bts_pkg::POS_W-1:0]           position
);

  logic [bts_pkg::COUNT_W-1:0] table_count;
  logic                        eng_idle;
  logic                        eng_res_valid;
  bts_pkg::res_t               eng_res;
  logic                        res_take;
  logic                        req_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
    end else if (cfg_we) begin
      table_count <= cfg_wdata;
    end
  end

  assign req_stall = !eng_idle;
  assign req_take  = req_valid && !req_stall;
  assign res_take  = eng_res_valid && (!rsp_valid || !rsp_stall);

  bts_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .take      (req_take),
    .op        (op),
    .index     (index),
    .entry     (entry),
    .key       (key),
    .count     (table_count),
    .idle      (eng_idle),
    .res_valid (eng_res_valid),
    .res       (eng_res),
    .res_take  (res_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
      found     <= eng_res.found;
      position  <= eng_res.position;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/bts_checker.sv
// ----------------------------------------------------------------------------
// Binary table search checker
// Port-level properties of the search block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "binary_table_search_defines.svh"

module bts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic [bts_pkg::OP_W-1:0]    op,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic                        found,
  input logic [bts_pkg::POS_W-1:0]   position
);

  `BTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(found) && $stable(position), "response changed while stalled")
  `BTS_ASSERT_NOW(a_miss_pos_zero, rsp_valid && !found, position == '0, "miss with non-zero position")
  `BTS_ASSERT_NEXT(a_load_no_block, req_valid && !req_stall && (op == bts_pkg::OP_LOAD), !req_stall, "load blocked the request channel")
  `BTS_ASSERT_NEXT(a_search_busy, req_valid && !req_stall && (op == bts_pkg::OP_SEARCH), req_stall, "search did not occupy the engine")

endmodule

bind binary_table_search bts_checker u_bts_checker (.*);

FILE: bench/binary_table_search_test.sv
// ----------------------------------------------------------------------------
// Binary table search: block-level test
// Loads the table and searches it under random sender gaps and receiver
// stalls. Every answer is checked against a local mirror of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_table_search_test;

  localparam int RESET_CYCLES = 7;
  localparam int SETTLE_CYCLES = 20;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES = 400000;
  localparam int BLOCK_ITEMS = 60;
  // lower half of the table is filled, so every first probe lands on data
  localparam int FILL_ENTRIES = bts_pkg::DEPTH / 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [bts_pkg::COUNT_W-1:0] cfg_wdata = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [bts_pkg::OP_W-1:0] op = bts_pkg::OP_LOAD;
  logic [bts_pkg::INDEX_W-1:0] index = '0;
  logic signed [bts_pkg::DATA_W-1:0] entry = '0;
  logic signed [bts_pkg::DATA_W-1:0] key = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic found;
  logic [bts_pkg::POS_W-1:0] position;

  // Mirror of the block: table contents, which entries hold data, count in use
  logic signed [bts_pkg::DATA_W-1:0] entries_mirror [bts_pkg::DEPTH];
  bit entry_loaded [bts_pkg::DEPTH];
  int count_mirror = 0;

  bts_pkg::res_t pending_results[$];
  int mismatches = 0;
  int cycle_count = 0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_orders = 0;
  int hold_served = 0;
  int hold_left = 0;

  binary_table_search dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .index     (index),
    .entry     (entry),
    .key       (key),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .found     (found),
    .position  (position)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is ordered
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_orders != hold_served) begin
      hold_served <= hold_orders;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    bts_pkg::res_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, found %0b position %0d", $time, found,
                 position);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) begin
          $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found,
                   found);
          mismatches++;
        end
        if (position !== want.position) begin
          $display("%0t: position mismatch, expected %0d, actual %0d", $time,
                   want.position, position);
          mismatches++;
        end
      end
    end
  end

  function automatic int effective_count();
    return (count_mirror > bts_pkg::DEPTH) ? bts_pkg::DEPTH : count_mirror;
  endfunction

  function automatic bts_pkg::res_t search_table(input logic signed [bts_pkg::DATA_W-1:0] k);
    bts_pkg::res_t r;
    int lo;
    int hi;
    int mid;
    r = '0;
    lo = 0;
    hi = effective_count() - 1;
    while (lo <= hi && !r.found) begin
      mid = (lo + hi) / 2;
      if (entries_mirror[mid] == k) begin
        r.found = 1'b1;
        r.position = mid[bts_pkg::POS_W-1:0];
      end else if (k < entries_mirror[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  // True when every entry the search for k would probe holds data
  function automatic bit path_loaded(input logic signed [bts_pkg::DATA_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = effective_count() - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (!entry_loaded[mid]) return 1'b0;
      if (entries_mirror[mid] == k) return 1'b1;
      if (k < entries_mirror[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return 1'b1;
  endfunction

  // Offer one request; valid stays high after acceptance so back-to-back
  // requests need no second assignment in the same step.
  task automatic send_request(input logic [bts_pkg::OP_W-1:0] o,
                              input logic [bts_pkg::INDEX_W-1:0] i,
                              input logic signed [bts_pkg::DATA_W-1:0] e,
                              input logic signed [bts_pkg::DATA_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    op <= o;
    index <= i;
    entry <= e;
    key <= k;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (o == bts_pkg::OP_LOAD) begin
      entries_mirror[i] = e;
      entry_loaded[i] = 1'b1;
    end else begin
      pending_results.push_back(search_table(k));
    end
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input int value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value[bts_pkg::COUNT_W-1:0];
    @(posedge clk);
    count_mirror = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic search_for(input logic signed [bts_pkg::DATA_W-1:0] k);
    logic [bts_pkg::INDEX_W-1:0] junk_index;
    logic signed [bts_pkg::DATA_W-1:0] junk_entry;
    logic signed [bts_pkg::DATA_W-1:0] safe_key;
    junk_index = $urandom;
    junk_entry = $urandom;
    safe_key = k;
    // never probe an empty entry: fall back to the value at the first probe
    if (!path_loaded(safe_key)) safe_key = entries_mirror[(effective_count() - 1) / 2];
    send_request(bts_pkg::OP_SEARCH, junk_index, junk_entry, safe_key);
  endtask

  task automatic load_entry(input int i, input logic signed [bts_pkg::DATA_W-1:0] e);
    logic signed [bts_pkg::DATA_W-1:0] junk_key;
    junk_key = $urandom;
    send_request(bts_pkg::OP_LOAD, i[bts_pkg::INDEX_W-1:0], e, junk_key);
  endtask

  task automatic test_directed();
    logic signed [bts_pkg::DATA_W-1:0] sorted_vals [8];
    int i;
    sorted_vals = '{-32768, -500, -1, 0, 1, 77, 1000, 32767};
    // empty table: no entry is probed
    write_count(0);
    search_for(16'sd0);
    for (i = 0; i < 8; i++) load_entry(i, sorted_vals[i]);
    load_entry(bts_pkg::DEPTH - 1, 16'sd32767);
    write_count(8);
    search_for(-16'sd32768);
    search_for(16'sd32767);
    search_for(16'sd2);
    search_for(16'sd77);
    write_count(1);
    search_for(-16'sd32768);
    search_for(16'sd32767);
    // break the ordering and search as written
    load_entry(3, 16'sd5000);
    write_count(8);
    search_for(16'sd1);
  endtask

  task automatic test_full_table();
    int i;
    int v;
    v = -32768 + $urandom_range(40);
    for (i = 0; i < FILL_ENTRIES; i++) begin
      load_entry(i, v[bts_pkg::DATA_W-1:0]);
      v = v + $urandom_range(63);
      if (v > 32767) v = 32767;
    end
    write_count(FILL_ENTRIES);
    for (i = 0; i < 10; i++) search_for(entries_mirror[$urandom_range(FILL_ENTRIES - 1)]);
    search_for(entries_mirror[0]);
    search_for(entries_mirror[FILL_ENTRIES - 1]);
    // whole table in use: keys up to the top filled entry stay in the lower half
    write_count(bts_pkg::DEPTH);
    search_for(entries_mirror[0]);
    search_for(entries_mirror[FILL_ENTRIES - 1]);
    // counts beyond the table saturate
    write_count(2047);
    search_for(entries_mirror[FILL_ENTRIES - 1]);
    search_for(entries_mirror[$urandom_range(FILL_ENTRIES - 1)]);
    write_count(bts_pkg::DEPTH + 1);
    search_for(entries_mirror[$urandom_range(FILL_ENTRIES - 1)]);
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    stall_pct = 0;
    write_count(bts_pkg::DEPTH);
    hold_orders++;
    for (i = 0; i < 40; i++) search_for(entries_mirror[$urandom_range(FILL_ENTRIES - 1)]);
    drain_results();
  endtask

  task automatic pick_count();
    int c;
    case ($urandom_range(7))
      0: c = 0;
      1: c = 1;
      2: c = $urandom_range(3, 2);
      3: c = bts_pkg::DEPTH;
      4: c = $urandom_range(2047, bts_pkg::DEPTH + 1);
      5: c = 2047;
      default: c = $urandom_range(bts_pkg::DEPTH - 1, 4);
    endcase
    write_count(c);
  endtask

  task automatic run_random_block();
    int i;
    int n;
    int pick;
    int lo_i;
    int hi_i;
    int slot;
    logic signed [bts_pkg::DATA_W-1:0] k;
    for (i = 0; i < BLOCK_ITEMS; i++) begin
      n = effective_count();
      pick = $urandom_range(99);
      if ($urandom_range(99) < 85) begin
        if (n == 0 || pick >= 80) begin
          k = $urandom;
        end else begin
          slot = $urandom_range(n - 1);
          if (entry_loaded[slot]) k = entries_mirror[slot];
          else k = $urandom;
          if (pick >= 60) k = k + ($urandom_range(1) ? 16'sd1 : -16'sd1);
        end
        search_for(k);
      end else begin
        slot = $urandom_range(bts_pkg::DEPTH - 1);
        lo_i = (slot == 0) ? -32768 : int'(entries_mirror[slot - 1]);
        hi_i = (slot == bts_pkg::DEPTH - 1) ? 32767 : int'(entries_mirror[slot + 1]);
        // keep the order most of the time, scribble otherwise
        if (pick < 70 && lo_i <= hi_i) k = lo_i + $urandom_range(hi_i - lo_i);
        else k = $urandom;
        load_entry(slot, k);
      end
    end
  endtask

  task automatic test_random();
    int phase;
    int blk;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 86; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 86; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      for (blk = 0; blk < 2; blk++) begin
        pick_count();
        run_random_block();
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
